@@ design/upum_pkg.sv @@
`default_nettype none
package upum_pkg;

	// Field and register widths
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 4;
	localparam int CFG_W      = 16;
	localparam int XI_W       = 15;
	localparam int XI_FRAC    = 14;
	localparam int SQRT_GUARD = 4;
	localparam int OUT_W      = 18;
	localparam int IDX_W      = 3;

	// Datapath widths
	localparam int PIX_W  = COORD_BITS + FRAC_BITS;
	localparam int MAG_W  = (PIX_W > CFG_W) ? PIX_W : CFG_W;
	localparam int D_W    = MAG_W + 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int RAD_W  = SUM_W + 2 * SQRT_GUARD;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int DSH    = XI_FRAC + SQRT_GUARD;
	localparam int XS_W   = XI_W + ROOT_W;
	localparam int FS_W   = CFG_W + DSH;
	localparam int DEN_W  = ((XS_W > FS_W) ? XS_W : FS_W) + 1;
	localparam int DVS_W  = DEN_W + 1;
	localparam int Q_W    = OUT_W + 1;
	localparam int PR_W   = MAG_W + CFG_W;
	localparam int NUM_W  = (((PR_W + DSH + 1) > DEN_W) ? (PR_W + DSH + 1) : DEN_W) + 1;
	localparam int HI_W   = NUM_W - Q_W;
	localparam int CMP_W  = (HI_W > DVS_W) ? HI_W : DVS_W;
	localparam int V_W    = Q_W + 2;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Register map
	typedef enum logic [IDX_W-1:0] {
		IDX_FOCAL_OUT     = 3'd0,
		IDX_MIRROR_OFFSET = 3'd1,
		IDX_CENTRE_OUT_X  = 3'd2,
		IDX_CENTRE_OUT_Y  = 3'd3,
		IDX_FOCAL_SRC     = 3'd4,
		IDX_CENTRE_SRC_X  = 3'd5,
		IDX_CENTRE_SRC_Y  = 3'd6
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] RST_FOCAL_OUT    = 16'd8000;
	localparam logic [XI_W-1:0]  RST_MIRROR       = 15'd16384;
	localparam logic [CFG_W-1:0] RST_CENTRE_OUT_X = 16'd15360;
	localparam logic [CFG_W-1:0] RST_CENTRE_OUT_Y = 16'd11520;
	localparam logic [CFG_W-1:0] RST_FOCAL_SRC    = 16'd8000;
	localparam logic [CFG_W-1:0] RST_CENTRE_SRC_X = 16'd5120;
	localparam logic [CFG_W-1:0] RST_CENTRE_SRC_Y = 16'd3840;

endpackage
`default_nettype wire

@@ design/unified_projection_undistort_map_top.sv @@
`default_nettype none
// Channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------
// input    | in_valid / in_ready       | pixel_col, pixel_row
// output   | out_valid / out_ready     | src_col, src_row, clipped
// config   | cfg_we (no wait)          | cfg_idx, cfg_data
//
// One request per cycle in, unless the pipeline is stalled; the square root
// and the divider are bit-per-stage pipelines.
// The whole pipeline advances together; it stalls only when the output
// register holds a request that is not taken. Reset clears valid bits and
// loads the register defaults.
module unified_projection_undistort_map_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [upum_pkg::IDX_W-1:0]         cfg_idx,
	input  wire logic [upum_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [upum_pkg::COORD_BITS-1:0]    pixel_col,
	input  wire logic [upum_pkg::COORD_BITS-1:0]    pixel_row,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [upum_pkg::OUT_W-1:0]       src_col,
	output logic signed [upum_pkg::OUT_W-1:0]       src_row,
	output logic                                    clipped
);
	import upum_pkg::*;

	localparam int L = 3 + ROOT_W + 2 + (Q_W + 1) + 1;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             sx;
		logic             sy;
	} mag_t;

	typedef struct packed {
		logic sx;
		logic sy;
		logic dz;
	} sgn_t;

	// Configuration registers
	logic [CFG_W-1:0] focal_out_q, centre_out_x_q, centre_out_y_q;
	logic [CFG_W-1:0] focal_src_q, centre_src_x_q, centre_src_y_q;
	logic [XI_W-1:0]  mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_out_q    <= RST_FOCAL_OUT;
			mirror_q       <= RST_MIRROR;
			centre_out_x_q <= RST_CENTRE_OUT_X;
			centre_out_y_q <= RST_CENTRE_OUT_Y;
			focal_src_q    <= RST_FOCAL_SRC;
			centre_src_x_q <= RST_CENTRE_SRC_X;
			centre_src_y_q <= RST_CENTRE_SRC_Y;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				IDX_FOCAL_OUT:     focal_out_q    <= cfg_data;
				IDX_MIRROR_OFFSET: mirror_q       <= cfg_data[XI_W-1:0];
				IDX_CENTRE_OUT_X:  centre_out_x_q <= cfg_data;
				IDX_CENTRE_OUT_Y:  centre_out_y_q <= cfg_data;
				IDX_FOCAL_SRC:     focal_src_q    <= cfg_data;
				IDX_CENTRE_SRC_X:  centre_src_x_q <= cfg_data;
				IDX_CENTRE_SRC_Y:  centre_src_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance
	logic       en;
	logic [L-1:0] vld_q;

	assign out_valid = vld_q[L-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	// s1: offsets from the output principal point, magnitude and sign
	logic signed [D_W-1:0] dx, dy;
	logic [MAG_W-1:0]      ax_s1, ay_s1;
	logic                  sx_s1, sy_s1;

	assign dx = $signed(D_W'({pixel_col, {FRAC_BITS{1'b0}}})) - $signed(D_W'(centre_out_x_q));
	assign dy = $signed(D_W'({pixel_row, {FRAC_BITS{1'b0}}})) - $signed(D_W'(centre_out_y_q));

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= dx[D_W-1];
			sy_s1 <= dy[D_W-1];
			ax_s1 <= dx[D_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
			ay_s1 <= dy[D_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
		end
	end

	// s2: squares
	logic [SQ_W-1:0]  sqx_s2, sqy_s2, sqf_s2;
	logic [MAG_W-1:0] ax_s2, ay_s2;
	logic             sx_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			sqf_s2 <= SQ_W'(focal_out_q * focal_out_q);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
		end
	end

	// s3: radicand with guard bits
	logic [RAD_W-1:0] rad_s3;
	mag_t             mag_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= {SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqf_s2),
			           {(2*SQRT_GUARD){1'b0}}};
			mag_s3 <= '{ax: ax_s2, ay: ay_s2, sx: sx_s2, sy: sy_s2};
		end
	end

	// Sphere norm
	logic [ROOT_W-1:0] root;

	upum_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s3),
		.root (root)
	);

	mag_t mag_dly [ROOT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_dly[0] <= mag_s3;
			for (int i = 1; i < ROOT_W; i++) begin
				mag_dly[i] <= mag_dly[i-1];
			end
		end
	end

	// s4: xi * norm and numerator products
	logic [XS_W-1:0] xs_s4;
	logic [PR_W-1:0] px_s4, py_s4;
	logic            sx_s4, sy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s4 <= mirror_q * root;
			px_s4 <= mag_dly[ROOT_W-1].ax * focal_src_q;
			py_s4 <= mag_dly[ROOT_W-1].ay * focal_src_q;
			sx_s4 <= mag_dly[ROOT_W-1].sx;
			sy_s4 <= mag_dly[ROOT_W-1].sy;
		end
	end

	// s5: denominator, rounded dividends
	logic [DEN_W-1:0] den;
	logic [NUM_W-1:0] nx_s5, ny_s5;
	logic [DVS_W-1:0] dvs_s5;
	sgn_t             sgn_s5;

	assign den = DEN_W'(xs_s4) + DEN_W'({focal_out_q, {DSH{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5  <= NUM_W'({px_s4, {(DSH+1){1'b0}}}) + NUM_W'(den);
			ny_s5  <= NUM_W'({py_s4, {(DSH+1){1'b0}}}) + NUM_W'(den);
			dvs_s5 <= {den, 1'b0};
			sgn_s5 <= '{sx: sx_s4, sy: sy_s4, dz: (den == '0)};
		end
	end

	// Per-axis dividers
	logic [Q_W-1:0] qx, qy;

	upum_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nx_s5),
		.dvs (dvs_s5),
		.q   (qx)
	);

	upum_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (ny_s5),
		.dvs (dvs_s5),
		.q   (qy)
	);

	sgn_t sgn_dly [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_dly[0] <= sgn_s5;
			for (int i = 1; i < Q_W + 1; i++) begin
				sgn_dly[i] <= sgn_dly[i-1];
			end
		end
	end

	// Output stage: sign, add source centre, saturate
	sgn_t                  sg;
	logic signed [V_W-1:0] offx, offy, vx, vy;
	logic                  clx, cly;

	assign sg   = sgn_dly[Q_W];
	assign offx = sg.dz ? '0 : (sg.sx ? -$signed(V_W'(qx)) : $signed(V_W'(qx)));
	assign offy = sg.dz ? '0 : (sg.sy ? -$signed(V_W'(qy)) : $signed(V_W'(qy)));
	assign vx   = offx + $signed(V_W'(centre_src_x_q));
	assign vy   = offy + $signed(V_W'(centre_src_y_q));
	assign clx  = (vx > V_W'(OUT_MAX)) || (vx < V_W'(OUT_MIN));
	assign cly  = (vy > V_W'(OUT_MAX)) || (vy < V_W'(OUT_MIN));

	always_ff @(posedge clk) begin
		if (en) begin
			src_col <= (vx > V_W'(OUT_MAX)) ? OUT_MAX :
			           (vx < V_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(vx);
			src_row <= (vy > V_W'(OUT_MAX)) ? OUT_MAX :
			           (vy < V_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(vy);
			clipped <= clx || cly;
		end
	end

	// Checks
	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (src_col == OUT_MAX) || (src_col == OUT_MIN) ||
		                        (src_row == OUT_MAX) || (src_row == OUT_MIN))
		else $error("clipped without a saturated coordinate");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted request not in first stage");

endmodule
`default_nettype wire

@@ design/upum_sqrt.sv @@
`default_nettype none
module upum_sqrt (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [upum_pkg::RAD_W-1:0]  rad,
	output logic      [upum_pkg::ROOT_W-1:0] root
);
	import upum_pkg::*;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];

	// One root bit per stage, two radicand bits brought down each time
	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [REM_W-1:0]  pr_rem;
		logic [ROOT_W-1:0] pr_root;
		logic [RAD_W-1:0]  pr_rad;
		logic [REM_W+1:0]  t;
		logic [REM_W+1:0]  trial;

		if (i == 0) begin : g_first
			assign pr_rem  = '0;
			assign pr_root = '0;
			assign pr_rad  = rad;
		end else begin : g_next
			assign pr_rem  = rem_s[i-1];
			assign pr_root = root_s[i-1];
			assign pr_rad  = rad_s[i-1];
		end

		assign t     = {pr_rem, pr_rad[RAD_W-1 -: 2]};
		assign trial = (REM_W+2)'({pr_root, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= trial) begin
					rem_s[i]  <= REM_W'(t - trial);
					root_s[i] <= {pr_root[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= REM_W'(t);
					root_s[i] <= {pr_root[ROOT_W-2:0], 1'b0};
				end
				rad_s[i] <= {pr_rad[RAD_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule
`default_nettype wire

@@ design/upum_div.sv @@
`default_nettype none
module upum_div (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [upum_pkg::NUM_W-1:0] num,
	input  wire logic [upum_pkg::DVS_W-1:0] dvs,
	output logic      [upum_pkg::Q_W-1:0]   q
);
	import upum_pkg::*;

	logic             ovf_s0;
	logic [DVS_W-1:0] rem_s0;
	logic [Q_W-1:0]   lo_s0;
	logic [DVS_W-1:0] dvs_s0;

	logic             ovf_s [Q_W];
	logic [DVS_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   lo_s  [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];
	logic [DVS_W-1:0] dvs_s [Q_W];

	// Overflow check: quotient would not fit, cap it
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s0 <= CMP_W'(num[NUM_W-1:Q_W]) >= CMP_W'(dvs);
			rem_s0 <= DVS_W'(num[NUM_W-1:Q_W]);
			lo_s0  <= num[Q_W-1:0];
			dvs_s0 <= dvs;
		end
	end

	// Restoring division, one quotient bit per stage
	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic             pr_ovf;
		logic [DVS_W-1:0] pr_rem;
		logic [Q_W-1:0]   pr_lo;
		logic [Q_W-1:0]   pr_q;
		logic [DVS_W-1:0] pr_dvs;
		logic [DVS_W:0]   t;

		if (k == 0) begin : g_first
			assign pr_ovf = ovf_s0;
			assign pr_rem = rem_s0;
			assign pr_lo  = lo_s0;
			assign pr_q   = '0;
			assign pr_dvs = dvs_s0;
		end else begin : g_next
			assign pr_ovf = ovf_s[k-1];
			assign pr_rem = rem_s[k-1];
			assign pr_lo  = lo_s[k-1];
			assign pr_q   = q_s[k-1];
			assign pr_dvs = dvs_s[k-1];
		end

		assign t = {pr_rem, pr_lo[Q_W-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, pr_dvs}) begin
					rem_s[k] <= DVS_W'(t - {1'b0, pr_dvs});
					q_s[k]   <= {pr_q[Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= DVS_W'(t);
					q_s[k]   <= {pr_q[Q_W-2:0], 1'b0};
				end
				lo_s[k]  <= {pr_lo[Q_W-2:0], 1'b0};
				ovf_s[k] <= pr_ovf;
				dvs_s[k] <= pr_dvs;
			end
		end
	end

	assign q = ovf_s[Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : q_s[Q_W-1];

endmodule
`default_nettype wire
